### rtl/bat_pkg.sv
// bat_pkg: shared types and codes for the breakpoint address table
// holds the request packet that walks the cell chain, op and status codes
// no dependencies
package bat_pkg;

    localparam int BAT_ENTRIES = 16;
    localparam int BAT_ADDR_W  = 32;
    localparam int BAT_OP_W    = 2;
    localparam int BAT_ST_W    = 3;

    localparam logic [BAT_OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [BAT_OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [BAT_OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [BAT_ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [BAT_ST_W-1:0] ST_MISALIGNED = 3'd1;
    localparam logic [BAT_ST_W-1:0] ST_PRESENT    = 3'd2;
    localparam logic [BAT_ST_W-1:0] ST_ABSENT     = 3'd3;
    localparam logic [BAT_ST_W-1:0] ST_FULL       = 3'd4;

    // packet handed from cell to cell, one hop per cycle
    // mark: free entry seen (query pass) or entry claimed (commit pass)
    typedef struct packed {
        logic                  vld;
        logic                  commit;
        logic                  add;
        logic [BAT_ADDR_W-1:0] addr;
        logic                  hit;
        logic                  mark;
    } t_pkt;

endpackage

### rtl/breakpoint_address_table.sv
// path: a request is registered, walks the cell chain as a query pass, then as a commit
// pass if an add or remove writes the table; the verdict is registered, then moved out
// throughput: one request at a time, the next taken the cycle after the result
// is moved to the output register; set by the request walking the cell chain
// reset: synchronous, clears all entry valid bits, the chain and the output valid
module breakpoint_address_table #(
    parameter int ENTRIES = bat_pkg::BAT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bat_pkg::BAT_OP_W-1:0]   i_op,
    input  logic [bat_pkg::BAT_ADDR_W-1:0] i_address,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [bat_pkg::BAT_ST_W-1:0]   o_status
);
    import bat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_QUERY  = 4'b0010,
        S_COMMIT = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [BAT_OP_W-1:0]   r_req_op;
    logic [BAT_ADDR_W-1:0] r_req_addr;
    t_pkt                  r_inj;
    t_pkt                  n_inj;
    logic                  r_res_hit;
    logic                  n_res_hit;
    logic [BAT_ST_W-1:0]   r_res_status;
    logic [BAT_ST_W-1:0]   n_res_status;
    logic                  r_o_valid;
    logic                  n_o_valid;
    logic                  r_o_hit;
    logic                  n_o_hit;
    logic [BAT_ST_W-1:0]   r_o_status;
    logic [BAT_ST_W-1:0]   n_o_status;

    t_pkt                  w_chain [0:ENTRIES];
    t_pkt                  w_tail;
    logic                  w_accept;
    logic                  w_modify;
    logic                  w_aligned;
    logic [BAT_ST_W-1:0]   w_status;
    logic                  w_commit;

    assign w_chain[0] = r_inj;
    assign w_tail     = w_chain[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pkt   (w_chain[g]),
            .o_pkt   (w_chain[g+1])
        );
    end

    assign o_stall   = (r_state != S_IDLE);
    assign w_accept  = i_valid && !o_stall;
    assign w_modify  = (r_req_op == OP_ADD) || (r_req_op == OP_REMOVE);
    assign w_aligned = (r_req_addr[1:0] == 2'b00);

    // verdict once the query pass leaves the last cell
    always_comb begin
        w_status = ST_OK;
        w_commit = 1'b0;
        priority if (!w_modify) begin
            w_status = ST_OK;
        end else if (!w_aligned) begin
            w_status = ST_MISALIGNED;
        end else if (r_req_op == OP_ADD) begin
            priority if (w_tail.hit) begin
                w_status = ST_PRESENT;
            end else if (!w_tail.mark) begin
                w_status = ST_FULL;
            end else begin
                w_commit = 1'b1;
            end
        end else begin
            if (!w_tail.hit) begin
                w_status = ST_ABSENT;
            end else begin
                w_commit = 1'b1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_inj        = r_inj;
        n_inj.vld    = 1'b0;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && i_stall;
        n_o_hit      = r_o_hit;
        n_o_status   = r_o_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_inj.vld    = 1'b1;
                    n_inj.commit = 1'b0;
                    n_inj.add    = (i_op == OP_ADD);
                    n_inj.addr   = i_address;
                    n_inj.hit    = 1'b0;
                    n_inj.mark   = 1'b0;
                    n_state      = S_QUERY;
                end
            end
            S_QUERY: begin
                if (w_tail.vld) begin
                    n_res_hit    = w_tail.hit;
                    n_res_status = w_status;
                    if (w_commit) begin
                        n_inj.vld    = 1'b1;
                        n_inj.commit = 1'b1;
                        n_inj.add    = (r_req_op == OP_ADD);
                        n_inj.addr   = r_req_addr;
                        n_inj.hit    = 1'b0;
                        n_inj.mark   = 1'b0;
                        n_state      = S_COMMIT;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_COMMIT: begin
                if (w_tail.vld) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_hit    = r_res_hit;
                    n_o_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inj     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj     <= n_inj;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_op   <= i_op;
            r_req_addr <= i_address;
        end
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
        r_o_hit      <= n_o_hit;
        r_o_status   <= n_o_status;
    end

    assign o_valid  = r_o_valid;
    assign o_hit    = r_o_hit;
    assign o_status = r_o_status;

endmodule

### rtl/bat_cell.sv
// bat_cell: one entry of the breakpoint table plus its chain register
// compares the passing request with its entry, then hands it to the next cell
// depends on bat_pkg
module bat_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bat_pkg::t_pkt i_pkt,
    output bat_pkg::t_pkt o_pkt
);
    import bat_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [BAT_ADDR_W-1:0] r_addr;
    logic [BAT_ADDR_W-1:0] n_addr;
    t_pkt                  r_pkt;
    t_pkt                  n_pkt;
    logic                  w_match;

    assign w_match = r_valid && (r_addr == i_pkt.addr);

    always_comb begin
        n_pkt   = i_pkt;
        n_valid = r_valid;
        n_addr  = r_addr;
        if (i_pkt.vld) begin
            if (!i_pkt.commit) begin
                n_pkt.hit  = i_pkt.hit | w_match;
                n_pkt.mark = i_pkt.mark | !r_valid;
            end else if (i_pkt.add) begin
                // lowest free entry takes the address
                if (!i_pkt.mark && !r_valid) begin
                    n_addr     = i_pkt.addr;
                    n_valid    = 1'b1;
                    n_pkt.mark = 1'b1;
                end
            end else if (w_match) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pkt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pkt   <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign o_pkt = r_pkt;

endmodule

### rtl/bat_checker.sv
// bat_port_checks: port-level checks for the breakpoint address table
// bound to breakpoint_address_table; depends on bat_pkg
module bat_port_checks (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_hit,
    input logic [bat_pkg::BAT_ST_W-1:0]   o_status
);
    import bat_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_status))
        else $error("stalled result changed");

    // one request at a time: busy right after taking one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    // duplicate add implies hit, absent remove implies no hit
    a_status_vs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != ST_PRESENT || o_hit) && (o_status != ST_ABSENT || !o_hit))
        else $error("status disagrees with hit");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_MISALIGNED ||
                     o_status == ST_PRESENT || o_status == ST_ABSENT ||
                     o_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind breakpoint_address_table bat_port_checks u_bat_port_checks (.*);

### dv/bat_checker.sv
// bat_checker: watches both channels of the breakpoint address table, predicts each result
// and compares it; hands the failure and outstanding counts to tb_top
// depends on bat_pkg
module bat_checker #(
    parameter int ENTRIES = bat_pkg::BAT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_stall,
    input  logic [bat_pkg::BAT_OP_W-1:0]   i_op,
    input  logic [bat_pkg::BAT_ADDR_W-1:0] i_address,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_stall,
    input  logic                           i_hit,
    input  logic [bat_pkg::BAT_ST_W-1:0]   i_status,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                hit;
        logic [BAT_ST_W-1:0] status;
    } t_bp_result;

    logic [BAT_ADDR_W-1:0] slot_addr [ENTRIES];
    logic                  slot_valid [ENTRIES];
    t_bp_result            awaited_results [$];
    int                    fail_count = 0;

    // applies one request to the shadow table and returns what the block should report
    function automatic t_bp_result apply_breakpoint_op(logic [BAT_OP_W-1:0] op,
                                                       logic [BAT_ADDR_W-1:0] addr);
        int         match_idx;
        int         free_idx;
        t_bp_result res;
        match_idx  = -1;
        free_idx   = -1;
        res.status = ST_OK;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
                if (match_idx < 0 && slot_addr[i] == addr) match_idx = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        res.hit = (match_idx >= 0);
        // check and the spare op code leave the table alone and always report ok
        if (op == OP_ADD || op == OP_REMOVE) begin
            if (addr[1:0] != 2'b00) begin
                res.status = ST_MISALIGNED;
            end else if (op == OP_ADD) begin
                if (match_idx >= 0) begin
                    res.status = ST_PRESENT;
                end else if (free_idx < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_addr[free_idx]  = addr;
                    slot_valid[free_idx] = 1'b1;
                end
            end else if (match_idx < 0) begin
                res.status = ST_ABSENT;
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i] && slot_addr[i] == addr) slot_valid[i] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_bp_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_addr[i]  = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                awaited_results.push_back(apply_breakpoint_op(i_op, i_address));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result with nothing awaited: hit %0b status %0d",
                                           i_hit, i_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (want.hit !== i_hit || want.status !== i_status) begin
                        note_failure($sformatf("expected hit %0b status %0d, got hit %0b status %0d",
                                               want.hit, want.status, i_hit, i_status));
                    end
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

### dv/tb_top.sv
// tb_top: clock, reset and request stimulus for the breakpoint address table,
// with receiver stalls and the final verdict; checking is done in bat_checker
// depends on bat_pkg, breakpoint_address_table and bat_checker
module tb_top;
    import bat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // op code the block treats like a check
    localparam logic [BAT_OP_W-1:0] OP_SPARE = 2'd3;
    localparam int POOL_SIZE = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [BAT_OP_W-1:0]   i_op;
    logic [BAT_ADDR_W-1:0] i_address;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_hit;
    logic [BAT_ST_W-1:0]   o_status;
    int                    fail_count;
    int                    pending;
    int                    sent_count = 0;
    logic [BAT_ADDR_W-1:0] addr_pool [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    breakpoint_address_table dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_op      (i_op),
        .i_address (i_address),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_hit     (o_hit),
        .o_status  (o_status)
    );

    bat_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_hit        (o_hit),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_request(input logic [BAT_OP_W-1:0] op,
                                input logic [BAT_ADDR_W-1:0] addr);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_op      <= op;
        i_address <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // add-heavy phases fill the table, remove-heavy ones drain it
    task automatic send_random_request(input bit add_heavy);
        logic [BAT_OP_W-1:0]   op;
        logic [BAT_ADDR_W-1:0] addr;
        int                    roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            // noise: any address, but never an aligned add that would clog the table
            op   = BAT_OP_W'($urandom_range(0, 3));
            addr = $urandom;
            if (op == OP_ADD && addr[1:0] == 2'b00) addr[0] = 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 5)                         op = OP_SPARE;
            else if (roll < 25)                   op = OP_CHECK;
            else if (roll < (add_heavy ? 85 : 40)) op = OP_ADD;
            else                                  op = OP_REMOVE;
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 9) == 0) addr[1:0] = 2'($urandom_range(1, 3));
        end
        send_request(op, addr);
    endtask

    initial begin
        int items;
        int burst;
        int gap;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_op      = OP_CHECK;
        i_address = '0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFC;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom & 32'hFFFF_FFFC;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_ADD,    32'h0000_0000);
        send_request(OP_ADD,    32'hFFFF_FFFC);
        send_request(OP_ADD,    32'h0000_0000);   // duplicate
        send_request(OP_ADD,    32'h0000_1003);   // misaligned
        send_request(OP_CHECK,  32'h0000_0000);
        send_request(OP_CHECK,  32'hFFFF_FFFF);   // misaligned check still ok
        send_request(OP_SPARE,  32'hFFFF_FFFC);
        send_request(OP_REMOVE, 32'h0000_0008);   // absent
        send_request(OP_REMOVE, 32'hFFFF_FFFE);   // misaligned
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_CHECK,  32'h0000_0000);
        // fill every slot, then one more add hits the full table
        for (int k = 1; k < BAT_ENTRIES; k++) begin
            send_request(OP_ADD, (32'(k) << 28) | (32'(k) << 2));
        end
        send_request(OP_ADD, 32'h8000_0000);
        wait_all_results();

        for (int phase = 0; phase < 10; phase++) begin
            items = 0;
            while (items < 125) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++) send_random_request(phase % 2 == 0);
                items += burst;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) pause_sender(gap);
            end
            if (phase % 2 == 1) wait_all_results();
        end

        wait_all_results();
        repeat (2 * BAT_ENTRIES + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // receiver stalls: stretches of random modes, and one long hold-off
    initial begin
        int  mode;
        int  span;
        int  cyc;
        bit  held_off;
        i_stall  = 1'b0;
        held_off = 1'b0;
        cyc      = 0;
        wait (i_rst_n);
        forever begin
            if (!held_off && sent_count >= 400) begin
                held_off = 1'b1;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (299) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(negedge i_clk);
                cyc++;
                unique case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 2) != 0);
                    end
                    default: begin
                        i_stall <= ((cyc % 7) < 3);
                    end
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### breakpoint_address_table.f
rtl/bat_pkg.sv
rtl/bat_cell.sv
rtl/breakpoint_address_table.sv
rtl/bat_checker.sv
dv/bat_checker.sv
dv/tb_top.sv
